/* design/ttam_pkg.sv */
`default_nettype none

package ttam_pkg;

    // Configuration register map (index = paddr / 4)
    localparam int APB_AW = 4;

    localparam logic [1:0] REG_HIGH = 2'd0;
    localparam logic [1:0] REG_HYST = 2'd1;
    localparam logic [1:0] REG_CRIT = 2'd2;

    // Event kinds
    localparam logic [1:0] KIND_ERROR = 2'd0;
    localparam logic [1:0] KIND_HIGH  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_CRIT  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         channel;
        logic signed [15:0] temperature;
        logic signed [15:0] threshold;
        logic [31:0]        stamp;
        logic               last;
        logic [31:0]        alert_total;
        logic [31:0]        error_total;
    } event_t;

endpackage

`default_nettype wire

/* design/ttam_ram.sv */
`default_nettype none

// Simple dual-port RAM, registered read, read data holds while re is low.
module ttam_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/thermal_threshold_alert_monitor.sv */
`default_nettype none

// Thermal threshold alert monitor. Each transfer on the s_ channel carries one
// reading (channel, signed deci-degree temperature, read-failure flag, ms
// timestamp) and yields zero, one or two event transfers on the m_ channel:
// sensor error, alert high, alert clear and critical, in that order, the
// final one flagged by m_last_event. Every event carries the running alert and
// error totals after its reading. Per-channel alert flags live in a small
// synchronous RAM; a registered read is followed by a compare/modify/write-back
// stage, with forwarding when consecutive readings hit the same channel.
// An event passes the stage 1 registers and the output register before it is
// visible at m_. With m_ready held high the block takes one reading per cycle;
// a reading that yields two events holds off the next reading while the second
// event waits in a one-entry pending slot behind the output register. Alert
// flags are valid bits plus RAM data, so reset clears them at once with no
// clearing pass. Readings on a channel at or beyond CHANNELS are taken and
// dropped silently.
// Thresholds sit on an APB port at 0x0 (high), 0x4 (hysteresis), 0x8
// (critical); write them only while the block is idle.
module thermal_threshold_alert_monitor #(
    parameter int CHANNELS = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    // Readings
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [2:0]                  s_channel,
    input  wire logic signed [15:0]          s_temperature,
    input  wire logic                        s_read_failed,
    input  wire logic [31:0]                 s_timestamp,

    // Events
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [1:0]                       m_event_kind,
    output logic [2:0]                       m_event_channel,
    output logic signed [15:0]               m_event_temperature,
    output logic signed [15:0]               m_event_threshold,
    output logic [31:0]                      m_event_time,
    output logic                             m_last_event,
    output logic [31:0]                      m_alert_total,
    output logic [31:0]                      m_error_total,

    // APB configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ttam_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import ttam_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // ---------------- configuration ----------------
    logic signed [15:0] high_thr_reg, hyst_thr_reg, crit_thr_reg;
    logic [1:0]         reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_thr_reg <= '0;
            hyst_thr_reg <= '0;
            crit_thr_reg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_HIGH: high_thr_reg <= pwdata[15:0];
                REG_HYST: hyst_thr_reg <= pwdata[15:0];
                REG_CRIT: crit_thr_reg <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HIGH: prdata = {{16{high_thr_reg[15]}}, high_thr_reg};
            REG_HYST: prdata = {{16{hyst_thr_reg[15]}}, hyst_thr_reg};
            REG_CRIT: prdata = {{16{crit_thr_reg[15]}}, crit_thr_reg};
            default:  prdata = '0;
        endcase
    end

    // ---------------- handshake control ----------------
    logic s1_valid_reg;
    logic out_valid_reg, out_valid_next;
    logic pend_valid_reg, pend_valid_next;
    logic out_free, s1_fire, accept;

    // Output side is empty after this edge: safe to drop up to two events in.
    assign out_free = !out_valid_reg || (m_ready && !pend_valid_reg);
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign accept   = s_valid && s_ready;

    // ---------------- stage 0: flag read ----------------
    logic [CHANNELS-1:0] vld_reg;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic                in_range;
    logic                wr_en, wr_data;
    logic [0:0]          rd_data;

    assign rd_addr  = AW'(s_channel);
    assign in_range = (32'(s_channel) < CHANNELS);

    ttam_ram #(
        .WIDTH (1),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_flag_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // ---------------- stage 1 registers ----------------
    logic [2:0]         s1_channel_reg;
    logic signed [15:0] s1_temp_reg;
    logic               s1_failed_reg;
    logic [31:0]        s1_time_reg;
    logic               s1_inrange_reg;
    logic               fwd_hit_reg, fwd_val_reg, ent_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_channel_reg <= s_channel;
            s1_temp_reg    <= s_temperature;
            s1_failed_reg  <= s_read_failed;
            s1_time_reg    <= s_timestamp;
            s1_inrange_reg <= in_range;
            // write-back landing on the entry being read: RAM gives old data
            fwd_hit_reg    <= wr_en && (wr_addr == rd_addr);
            fwd_val_reg    <= wr_data;
            ent_valid_reg  <= in_range && vld_reg[rd_addr];
        end
    end

    // ---------------- stage 1: evaluate and write back ----------------
    logic               flag;
    logic               hi_hit, crit_hit, clr_hit, raise;
    logic               have_p, have_a, have_b;
    logic [1:0]         p_kind;
    logic signed [15:0] p_temp, p_thr;
    logic [31:0]        alert_cnt_reg, alert_cnt_next;
    logic [31:0]        error_cnt_reg, error_cnt_next;
    event_t             ev_a, ev_b;

    assign flag = fwd_hit_reg ? fwd_val_reg : (ent_valid_reg && rd_data[0]);

    always_comb begin
        hi_hit   = (high_thr_reg != 16'sd0) && (s1_temp_reg >= high_thr_reg);
        raise    = hi_hit && !flag;
        clr_hit  = !hi_hit && flag && (s1_temp_reg < hyst_thr_reg);
        crit_hit = s1_inrange_reg && !s1_failed_reg &&
                   (crit_thr_reg != 16'sd0) && (s1_temp_reg >= crit_thr_reg);

        have_p = 1'b0;
        p_kind = KIND_ERROR;
        p_temp = '0;
        p_thr  = '0;
        wr_data = flag;
        alert_cnt_next = alert_cnt_reg;
        error_cnt_next = error_cnt_reg;

        if (s1_inrange_reg) begin
            priority if (s1_failed_reg) begin
                have_p         = 1'b1;
                error_cnt_next = error_cnt_reg + 32'd1;
            end else if (raise) begin
                have_p         = 1'b1;
                p_kind         = KIND_HIGH;
                p_temp         = s1_temp_reg;
                p_thr          = high_thr_reg;
                wr_data        = 1'b1;
                alert_cnt_next = alert_cnt_reg + 32'd1;
            end else if (clr_hit) begin
                have_p  = 1'b1;
                p_kind  = KIND_CLEAR;
                p_temp  = s1_temp_reg;
                wr_data = 1'b0;
            end else begin
                have_p = 1'b0;
            end
        end

        have_a = have_p || crit_hit;
        have_b = have_p && crit_hit;

        ev_b.kind        = KIND_CRIT;
        ev_b.channel     = s1_channel_reg;
        ev_b.temperature = s1_temp_reg;
        ev_b.threshold   = crit_thr_reg;
        ev_b.stamp       = s1_time_reg;
        ev_b.last        = 1'b1;
        ev_b.alert_total = alert_cnt_next;
        ev_b.error_total = error_cnt_next;

        ev_a = ev_b;
        if (have_p) begin
            ev_a.kind        = p_kind;
            ev_a.temperature = p_temp;
            ev_a.threshold   = p_thr;
            ev_a.last        = !crit_hit;
        end
    end

    assign wr_en   = s1_fire && s1_inrange_reg && !s1_failed_reg;
    assign wr_addr = AW'(s1_channel_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            alert_cnt_reg <= '0;
            error_cnt_reg <= '0;
        end else if (s1_fire) begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            alert_cnt_reg <= alert_cnt_next;
            error_cnt_reg <= error_cnt_next;
        end
    end

    // ---------------- output register and pending slot ----------------
    event_t out_ev_reg, out_ev_next;
    event_t pend_ev_reg, pend_ev_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_ev_next     = out_ev_reg;
        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next  = pend_valid_reg;
            out_ev_next     = pend_ev_reg;
            pend_valid_next = 1'b0;
        end
        if (s1_fire && have_a) begin
            out_valid_next  = 1'b1;
            out_ev_next     = ev_a;
            pend_valid_next = have_b;
            pend_ev_next    = ev_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_ev_reg  <= out_ev_next;
        pend_ev_reg <= pend_ev_next;
    end

    assign m_valid             = out_valid_reg;
    assign m_event_kind        = out_ev_reg.kind;
    assign m_event_channel     = out_ev_reg.channel;
    assign m_event_temperature = out_ev_reg.temperature;
    assign m_event_threshold   = out_ev_reg.threshold;
    assign m_event_time        = out_ev_reg.stamp;
    assign m_last_event        = out_ev_reg.last;
    assign m_alert_total       = out_ev_reg.alert_total;
    assign m_error_total       = out_ev_reg.error_total;

endmodule

`default_nettype wire

/* design/ttam_checker.sv */
`default_nettype none

module ttam_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [1:0]                  m_event_kind,
    input wire logic signed [15:0]          m_event_temperature,
    input wire logic signed [15:0]          m_event_threshold,
    input wire logic [31:0]                 m_event_time,
    input wire logic                        m_last_event,
    input wire logic [31:0]                 m_error_total
);

    import ttam_pkg::*;

    // stalled event holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind) &&
        $stable(m_event_time) && $stable(m_last_event) && $stable(m_error_total))
        else $error("event changed while stalled");

    // no event straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("event valid after reset");

    // sensor error carries no reading and no threshold, and is its reading's only event
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == KIND_ERROR |->
        m_event_temperature == 16'sd0 && m_event_threshold == 16'sd0 && m_last_event)
        else $error("malformed sensor-error event");

    // threshold events name a nonzero threshold that the reading reached
    a_thr_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == KIND_HIGH || m_event_kind == KIND_CRIT) |->
        m_event_threshold != 16'sd0 && m_event_temperature >= m_event_threshold)
        else $error("threshold event below its threshold");

    // a clear event carries no threshold
    a_clear_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == KIND_CLEAR |-> m_event_threshold == 16'sd0)
        else $error("clear event with threshold");

endmodule

bind thermal_threshold_alert_monitor ttam_checker u_ttam_checker (.*);

`default_nettype wire

/* verif/thermal_threshold_alert_monitor_test.sv */
module thermal_threshold_alert_monitor_test;
    import ttam_pkg::*;

    localparam int CHANNELS = 8;
    // Generous: roughly 1250 readings, each at worst two events behind random back-pressure.
    localparam int CYCLE_LIMIT = 400000;
    // Slack after the last event, covering readings that produce no event but are still in flight.
    localparam int SETTLE_CYCLES = 8;
    // Address 0xC decodes to no register; writes there must be dropped.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_channel = '0;
    logic signed [15:0] s_temperature = '0;
    logic s_read_failed = 1'b0;
    logic [31:0] s_timestamp = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_event_kind;
    logic [2:0] m_event_channel;
    logic signed [15:0] m_event_temperature;
    logic signed [15:0] m_event_threshold;
    logic [31:0] m_event_time;
    logic m_last_event;
    logic [31:0] m_alert_total;
    logic [31:0] m_error_total;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Local copy of the monitor state, advanced once per accepted reading.
    logic signed [15:0] high_level = '0;
    logic signed [15:0] hyst_level = '0;
    logic signed [15:0] crit_level = '0;
    logic alert_on [CHANNELS] = '{default: 1'b0};
    logic [31:0] raised_tally = '0;
    logic [31:0] failed_tally = '0;

    // Events still to arrive, oldest first.
    event_t pending_events [$];
    event_t want_event;

    int mismatches = 0;
    int cycle_count = 0;
    // Set for a stretch where neither side idles.
    logic steady = 1'b0;

    thermal_threshold_alert_monitor #(
        .CHANNELS(CHANNELS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_channel(s_channel),
        .s_temperature(s_temperature),
        .s_read_failed(s_read_failed),
        .s_timestamp(s_timestamp),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_event_kind(m_event_kind),
        .m_event_channel(m_event_channel),
        .m_event_temperature(m_event_temperature),
        .m_event_threshold(m_event_threshold),
        .m_event_time(m_event_time),
        .m_last_event(m_last_event),
        .m_alert_total(m_alert_total),
        .m_error_total(m_error_total),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure: ready drops with a chance of 16 in 100 unless steady is set.
    initial begin
        forever begin
            @(posedge aclk);
            m_ready <= steady || ($urandom_range(99) >= 16);
        end
    end

    // Watchdog: a hung handshake or a missing event ends up here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("** thermal_threshold_alert_monitor: FAILED **");
        $finish;
    end

    function automatic event_t event_of(input logic [1:0] kind, input logic [2:0] ch,
                                        input logic signed [15:0] temp,
                                        input logic signed [15:0] level,
                                        input logic [31:0] stamp);
        event_t ev;
        ev = '0;
        ev.kind = kind;
        ev.channel = ch;
        ev.temperature = temp;
        ev.threshold = level;
        ev.stamp = stamp;
        return ev;
    endfunction

    // Alarm logic: error on a failed read; otherwise a rising alert or a
    // hysteresis clear, then independently a critical event. The totals on
    // every event are those after the reading.
    function automatic void predict_events(input logic [2:0] ch,
                                           input logic signed [15:0] temp,
                                           input logic failed, input logic [31:0] stamp);
        event_t found [$];
        event_t ev;
        if (int'(ch) >= CHANNELS)
            return;
        if (failed) begin
            failed_tally++;
            found.push_back(event_of(KIND_ERROR, ch, '0, '0, stamp));
        end else begin
            if (high_level != 0 && temp >= high_level) begin
                if (!alert_on[ch]) begin
                    alert_on[ch] = 1'b1;
                    raised_tally++;
                    found.push_back(event_of(KIND_HIGH, ch, temp, high_level, stamp));
                end
            end else if (alert_on[ch] && temp < hyst_level) begin
                alert_on[ch] = 1'b0;
                found.push_back(event_of(KIND_CLEAR, ch, temp, '0, stamp));
            end
            if (crit_level != 0 && temp >= crit_level)
                found.push_back(event_of(KIND_CRIT, ch, temp, crit_level, stamp));
        end
        foreach (found[i]) begin
            ev = found[i];
            ev.last = (i == found.size() - 1);
            ev.alert_total = raised_tally;
            ev.error_total = failed_tally;
            pending_events.push_back(ev);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Every event transfer is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event, expected none, actual kind %0d channel %0d",
                         $time, m_event_kind, m_event_channel);
                mismatches++;
            end else begin
                want_event = pending_events.pop_front();
                check_field("event_kind", want_event.kind, m_event_kind);
                check_field("event_channel", want_event.channel, m_event_channel);
                check_field("event_temperature", want_event.temperature, m_event_temperature);
                check_field("event_threshold", want_event.threshold, m_event_threshold);
                check_field("event_time", want_event.stamp, m_event_time);
                check_field("last_event", want_event.last, m_last_event);
                check_field("alert_total", want_event.alert_total, m_alert_total);
                check_field("error_total", want_event.error_total, m_error_total);
            end
        end
    end

    // One reading transfer. Valid is only lowered for an idle cycle, so
    // back-to-back transfers keep it high without a glitch in the same step.
    task automatic send_reading(input logic [2:0] ch, input logic signed [15:0] temp,
                                input logic failed, input logic [31:0] stamp);
        while (!steady && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_channel <= ch;
        s_temperature <= temp;
        s_read_failed <= failed;
        s_timestamp <= stamp;
        do @(posedge aclk); while (!s_ready);
        predict_events(ch, temp, failed, stamp);
    endtask

    // Hold off the sender until every predicted event has arrived, then
    // allow for eventless readings still in the pipeline.
    task automatic wait_for_events();
        s_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write, then read back. Only called with the block idle.
    task automatic write_register(input logic [1:0] index, input logic signed [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({index, 2'b00});
        pwdata <= {{16{value[15]}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            REG_HIGH: high_level = value;
            REG_HYST: hyst_level = value;
            REG_CRIT: crit_level = value;
            default: ;
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            REG_HIGH: check_field("high_threshold readback", $unsigned(high_level), prdata[15:0]);
            REG_HYST: check_field("hysteresis readback", $unsigned(hyst_level), prdata[15:0]);
            REG_CRIT: check_field("critical readback", $unsigned(crit_level), prdata[15:0]);
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_thresholds(input logic signed [15:0] high,
                                    input logic signed [15:0] hyst,
                                    input logic signed [15:0] crit);
        write_register(REG_HIGH, high);
        write_register(REG_HYST, hyst);
        write_register(REG_CRIT, crit);
    endtask

    // Thresholds at reset are zero: both tests off, so only failed reads
    // give events. Extremes of temperature, channel and timestamp.
    task automatic test_failed_reads_at_reset();
        send_reading(3'd0, 16'sh7fff, 1'b0, 32'h0000_0001);
        send_reading(3'd7, -16'sh8000, 1'b0, 32'h8000_0000);
        send_reading(3'd0, 16'sh1234, 1'b1, 32'h0000_0000);
        send_reading(3'd7, -16'sh0001, 1'b1, 32'hffff_ffff);
        send_reading(3'd5, 16'sh0000, 1'b0, 32'haaaa_5555);
        wait_for_events();
    endtask

    // Raise, hold inside the band, clear just below hysteresis, double
    // events, and a failed read that leaves the alert alone.
    task automatic test_alert_and_hysteresis();
        write_thresholds(16'sd500, 16'sd450, 16'sd800);
        send_reading(3'd3, 16'sd500, 1'b0, 32'd100);
        send_reading(3'd3, 16'sd600, 1'b0, 32'd101);
        send_reading(3'd3, 16'sd450, 1'b0, 32'd102);
        send_reading(3'd3, 16'sd449, 1'b0, 32'd103);
        send_reading(3'd3, 16'sd900, 1'b0, 32'd104);
        send_reading(3'd3, 16'sd10, 1'b1, 32'd105);
        send_reading(3'd3, 16'sd100, 1'b0, 32'd106);
        send_reading(3'd5, 16'sd800, 1'b0, 32'd107);
        send_reading(3'd6, 16'sd799, 1'b0, 32'd108);
        wait_for_events();
    endtask

    // High test off: active alerts still clear through hysteresis. A write
    // to the unmapped address must change nothing.
    task automatic test_high_disabled();
        write_register(REG_UNUSED, 16'sh7fff);
        write_register(REG_HIGH, 16'sd0);
        write_register(REG_HYST, 16'sd100);
        send_reading(3'd5, 16'sd99, 1'b0, 32'd200);
        send_reading(3'd6, 16'sd900, 1'b0, 32'd201);
        send_reading(3'd6, -16'sd5, 1'b0, 32'd202);
        wait_for_events();
    endtask

    task automatic test_threshold_extremes();
        write_thresholds(-16'sh8000, -16'sh8000, 16'sh7fff);
        send_reading(3'd1, -16'sh8000, 1'b0, 32'd300);
        send_reading(3'd1, 16'sh7fff, 1'b0, 32'd301);
        send_reading(3'd2, 16'sd0, 1'b0, 32'd302);
        wait_for_events();
        write_thresholds(16'sh7fff, 16'sh7fff, -16'sh8000);
        send_reading(3'd1, 16'sh7fff, 1'b0, 32'd303);
        send_reading(3'd2, 16'sh7ffe, 1'b0, 32'd304);
        send_reading(3'd4, 16'sh7fff, 1'b0, 32'd305);
        wait_for_events();
    endtask

    // Readings mostly land within 20 tenths of a threshold so alerts
    // rise and clear often; the rest sit near zero or cover the whole range.
    function automatic logic signed [15:0] pick_temperature();
        int base;
        int t;
        case ($urandom_range(9))
            0, 1: return 16'($urandom);
            2, 3, 4: base = high_level;
            5, 6: base = hyst_level;
            7, 8: base = crit_level;
            default: base = 0;
        endcase
        t = base + int'($urandom_range(40)) - 20;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return 16'(t);
    endfunction

    task automatic test_random_readings();
        logic signed [15:0] high;
        int span;
        for (int phase = 0; phase < 8; phase++) begin
            wait_for_events();
            case ($urandom_range(5))
                0: write_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
                1: write_thresholds(16'sd0, 16'(int'($urandom_range(600)) - 200),
                                    16'(int'($urandom_range(1000)) - 200));
                default: begin
                    high = 16'(int'($urandom_range(1600)) - 400);
                    span = $urandom_range(600);
                    write_thresholds(high, 16'(int'(high) - int'($urandom_range(150))),
                                     ($urandom_range(3) == 0) ? 16'sd0 : 16'(int'(high) + span));
                end
            endcase
            if (phase == 6)
                write_register(REG_UNUSED, 16'($urandom));
            // One phase runs flat out on both sides.
            steady = (phase == 3);
            for (int n = 0; n < 150; n++) begin
                // Mid-phase hold-off until the event stream has drained.
                if (phase == 5 && n == 75)
                    wait_for_events();
                send_reading(3'($urandom_range(CHANNELS - 1)), pick_temperature(),
                             ($urandom_range(99) < 8), $urandom);
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_failed_reads_at_reset();
        test_alert_and_hysteresis();
        test_high_disabled();
        test_threshold_extremes();
        test_random_readings();
        wait_for_events();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("** thermal_threshold_alert_monitor: PASSED **");
        end else begin
            $display("** thermal_threshold_alert_monitor: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
design/ttam_pkg.sv
design/ttam_ram.sv
design/thermal_threshold_alert_monitor.sv
design/ttam_checker.sv
verif/thermal_threshold_alert_monitor_test.sv
